// ===== rtl/core/ipmd_pkg.sv =====
// Package for the incremental PID motor drive core.
// Holds field widths, register indexes and the types shared between the modules.
// Depends on nothing.
package ipmd_pkg;

    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF1_W    = 18;
    localparam int DIFF2_W    = 19;
    localparam int PROD_P_W   = GAIN_W + ERR_W;
    localparam int PROD_I_W   = GAIN_W + DIFF1_W;
    localparam int PROD_D_W   = GAIN_W + DIFF2_W;
    localparam int GAIN_SHIFT = 8;
    localparam int SUM_W      = 30;
    localparam int DUTY_W     = 12;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 12'd4095;

    localparam int PWM_MAX_DEFAULT     = 4095;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 2'd2;

    typedef struct packed {
        logic                    backward;
        logic signed [ERR_W-1:0] error;
    } item_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
    } gains_t;

endpackage

// ===== rtl/core/ipmd_front.sv =====
// Front stage of the motor drive core: takes a request and forms the speed error.
// Depends on ipmd_pkg for the item type and field widths.
module ipmd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              backward,
    input  logic signed [ipmd_pkg::DATA_W-1:0] target_speed,
    input  logic signed [ipmd_pkg::DATA_W-1:0] measured_speed,
    output ipmd_pkg::item_t                   push_item,
    output logic                              push,
    input  logic                              q_full
);
    import ipmd_pkg::*;

    logic  f_valid_reg;
    logic  f_valid_next;
    item_t f_item_reg;
    logic  load;
    logic signed [ERR_W-1:0] error;

    assign in_stall = f_valid_reg && q_full;
    assign load     = in_valid && !in_stall;
    assign push     = f_valid_reg && !q_full;
    assign error    = ERR_W'(target_speed) - ERR_W'(measured_speed);

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (load)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            f_item_reg.backward <= backward;
            f_item_reg.error    <= error;
        end
    end

    assign push_item = f_item_reg;

endmodule

// ===== rtl/core/ipmd_queue.sv =====
// Short request queue between the front and back parts of the drive core.
// Depends on ipmd_pkg for the item type.
module ipmd_queue #(
    parameter int DEPTH = ipmd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ipmd_pkg::item_t push_item,
    input  logic            pop,
    output ipmd_pkg::item_t head_item,
    output logic            not_empty,
    output logic            full
);
    import ipmd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("Request pushed into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("Request popped from an empty queue.");

endmodule

// ===== rtl/core/ipmd_back.sv =====
// Back part of the drive core: PID increment, saturating drive and PWM duty output.
// Depends on ipmd_pkg for widths, the item type and the gain set.
module ipmd_back #(
    parameter int PWM_MAX = ipmd_pkg::PWM_MAX_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ipmd_pkg::gains_t                  gains,
    input  ipmd_pkg::item_t                   head_item,
    input  logic                              q_not_empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ipmd_pkg::DUTY_W-1:0]       duty_a,
    output logic [ipmd_pkg::DUTY_W-1:0]       duty_b
);
    import ipmd_pkg::*;

    localparam int DRIVE_W = $clog2(PWM_MAX + 1) + 1;
    localparam int MAG_W   = DRIVE_W - 1;
    localparam int CMP_W   = (MAG_W > DUTY_W) ? MAG_W : DUTY_W;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(PWM_MAX);
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -DRIVE_MAX;
    localparam logic signed [SUM_W-1:0]   SUM_MAX   = SUM_W'(PWM_MAX);
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = -SUM_MAX;

    logic advance;

    logic signed [ERR_W-1:0]   err1_reg;
    logic signed [ERR_W-1:0]   err2_reg;
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF1_W-1:0] diff1;
    logic signed [DIFF2_W-1:0] diff2;

    logic                       s1_valid_reg;
    logic                       s1_back_reg;
    logic signed [PROD_P_W-1:0] s1_prod_p_reg;
    logic signed [PROD_I_W-1:0] s1_prod_i_reg;
    logic signed [PROD_D_W-1:0] s1_prod_d_reg;

    logic                    s2_valid_reg;
    logic                    s2_back_reg;
    logic signed [SUM_W-1:0] s2_inc_reg;
    logic signed [SUM_W-1:0] inc_next;

    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic signed [SUM_W-1:0]   acc;
    logic [MAG_W-1:0]          mag;
    logic [CMP_W-1:0]          mag_ext;
    logic [DUTY_W-1:0]         duty;

    logic              out_valid_reg;
    logic [DUTY_W-1:0] duty_a_reg;
    logic [DUTY_W-1:0] duty_b_reg;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && q_not_empty;

    assign err   = head_item.error;
    assign diff1 = DIFF1_W'(err) - DIFF1_W'(err1_reg);
    assign diff2 = DIFF2_W'(err) - (DIFF2_W'(err1_reg) <<< 1) + DIFF2_W'(err2_reg);

    assign inc_next = SUM_W'(signed'(s1_prod_p_reg[PROD_P_W-1:GAIN_SHIFT]))
                    + SUM_W'(signed'(s1_prod_i_reg[PROD_I_W-1:GAIN_SHIFT]))
                    + SUM_W'(signed'(s1_prod_d_reg[PROD_D_W-1:GAIN_SHIFT]));

    always_comb
    begin
        acc = SUM_W'(drive_reg) + s2_inc_reg;
        if (acc > SUM_MAX)
        begin
            drive_next = DRIVE_MAX;
        end
        else if (acc < SUM_MIN)
        begin
            drive_next = DRIVE_MIN;
        end
        else
        begin
            drive_next = acc[DRIVE_W-1:0];
        end
        if (drive_next[DRIVE_W-1])
        begin
            mag = MAG_W'(-drive_next);
        end
        else
        begin
            mag = drive_next[MAG_W-1:0];
        end
        mag_ext = CMP_W'(mag);
        if (mag_ext > CMP_W'(DUTY_MAX))
        begin
            duty = DUTY_MAX;
        end
        else
        begin
            duty = mag_ext[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            err1_reg      <= '0;
            err2_reg      <= '0;
            drive_reg     <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_not_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (q_not_empty)
            begin
                err2_reg <= err1_reg;
                err1_reg <= err;
            end
            if (s2_valid_reg)
            begin
                drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_back_reg   <= head_item.backward;
            s1_prod_p_reg <= gains.gain_p * err;
            s1_prod_i_reg <= gains.gain_i * diff1;
            s1_prod_d_reg <= gains.gain_d * diff2;
            s2_back_reg   <= s1_back_reg;
            s2_inc_reg    <= inc_next;
            duty_a_reg    <= s2_back_reg ? '0 : duty;
            duty_b_reg    <= s2_back_reg ? duty : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty_a    = duty_a_reg;
    assign duty_b    = duty_b_reg;

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_reg <= DRIVE_MAX) && (drive_reg >= DRIVE_MIN))
        else $error("Drive accumulator left its saturation range.");

    a_one_channel_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (duty_a_reg == '0) || (duty_b_reg == '0))
        else $error("Both PWM channels driven at once.");

    a_stall_keeps_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg)
            && $stable(drive_reg) && $stable(err1_reg)))
        else $error("Back pipeline moved while the output was stalled.");

endmodule

// ===== rtl/core/incremental_pid_motor_drive_core.sv =====
// Top level of the incremental PID motor drive core.
// Depends on ipmd_pkg, ipmd_front, ipmd_queue and ipmd_back.
//
// Each request on the input channel carries a direction select and a target and
// measured speed. The core forms the speed error, adds a velocity-form PID
// increment to a saturating drive level and returns one result per request:
// the drive magnitude on duty_a for forward or on duty_b for backward, with
// the other channel at zero.
// Both channels use valid and stall; a request moves on an edge with valid high
// and stall low. The gains are written through the plain cfg_write port; the user
// must write them only while the core is idle, as the core does not enforce it.
// A request is registered in the front stage, passes a short queue and runs
// through three back stages: products, increment sum, then drive update with
// the output register. One request is taken every cycle while in_stall is low.
// The pace is set by the drive accumulator, a combinational add and saturate.
// When the receiver stalls, the back stages hold and the queue absorbs up to
// QUEUE_DEPTH requests plus one in the front stage before in_stall rises.
// Reset clears the gains, the error history, the drive level and all valids.
module incremental_pid_motor_drive_core #(
    parameter int PWM_MAX     = ipmd_pkg::PWM_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = ipmd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [ipmd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ipmd_pkg::GAIN_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   backward,
    input  logic signed [ipmd_pkg::DATA_W-1:0]     target_speed,
    input  logic signed [ipmd_pkg::DATA_W-1:0]     measured_speed,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ipmd_pkg::DUTY_W-1:0]            duty_a,
    output logic [ipmd_pkg::DUTY_W-1:0]            duty_b
);
    import ipmd_pkg::*;

    gains_t gains_reg;
    item_t  push_item;
    item_t  head_item;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_P:
                begin
                    gains_reg.gain_p <= cfg_data;
                end
                REG_GAIN_I:
                begin
                    gains_reg.gain_i <= cfg_data;
                end
                REG_GAIN_D:
                begin
                    gains_reg.gain_d <= cfg_data;
                end
                default:
                begin
                    gains_reg <= gains_reg;
                end
            endcase
        end
    end

    ipmd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .backward       (backward),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .push_item      (push_item),
        .push           (push),
        .q_full         (q_full)
    );

    ipmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    ipmd_back #(
        .PWM_MAX (PWM_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .gains       (gains_reg),
        .head_item   (head_item),
        .q_not_empty (q_not_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty_a      (duty_a),
        .duty_b      (duty_b)
    );

endmodule

// ===== verif/incremental_pid_motor_drive_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for incremental_pid_motor_drive_core: sends speed requests and gain writes,
// predicts every duty result in the bench and checks the results in order.
// Depends on ipmd_pkg and the core RTL.
module incremental_pid_motor_drive_core_tb;
    import ipmd_pkg::*;

    localparam int DRIVE_LIMIT    = PWM_MAX_DEFAULT;
    localparam int DRIVE_W        = $clog2(DRIVE_LIMIT + 1) + 1;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
    } duty_pair_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [GAIN_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     backward;
    logic signed [DATA_W-1:0] target_speed;
    logic signed [DATA_W-1:0] measured_speed;
    logic                     out_valid;
    logic                     out_stall;
    logic [DUTY_W-1:0]        duty_a;
    logic [DUTY_W-1:0]        duty_b;

    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic signed [ERR_W-1:0]   err_last;
    logic signed [ERR_W-1:0]   err_older;
    logic signed [DRIVE_W-1:0] drive_acc;

    duty_pair_t expected_duty_q[$];
    int         fail_count   = 0;
    int         quiet_cycles = 0;
    bit         send_idle_on = 1'b1;
    bit         recv_idle_on = 1'b1;

    incremental_pid_motor_drive_core #(
        .PWM_MAX     (DRIVE_LIMIT),
        .QUEUE_DEPTH (QUEUE_DEPTH_DEFAULT)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .backward       (backward),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duty_a         (duty_a),
        .duty_b         (duty_b)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_speed();
        int v;
        if ($urandom_range(0, 4) == 0)
            v = $urandom;
        else
            v = int'($urandom_range(0, 600)) - 300;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int v;
        if ($urandom_range(0, 3) == 0)
            v = $urandom;
        else
            v = int'($urandom_range(0, 1024)) - 512;
        return v[GAIN_W-1:0];
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endfunction

    // Updates the error history and drive level for one request and returns its duties.
    function automatic duty_pair_t advance_drive(input logic back,
                                                 input logic signed [DATA_W-1:0] target,
                                                 input logic signed [DATA_W-1:0] measured);
        longint     err;
        longint     diff1;
        longint     diff2;
        longint     step;
        longint     acc;
        longint     mag;
        duty_pair_t res;
        err   = longint'(target) - longint'(measured);
        diff1 = err - longint'(err_last);
        diff2 = err - 2 * longint'(err_last) + longint'(err_older);
        step  = ((longint'(kp) * err) >>> GAIN_SHIFT)
              + ((longint'(ki) * diff1) >>> GAIN_SHIFT)
              + ((longint'(kd) * diff2) >>> GAIN_SHIFT);
        acc = longint'(drive_acc) + step;
        if (acc > DRIVE_LIMIT)
            acc = DRIVE_LIMIT;
        if (acc < -DRIVE_LIMIT)
            acc = -DRIVE_LIMIT;
        drive_acc = acc[DRIVE_W-1:0];
        err_older = err_last;
        err_last  = err[ERR_W-1:0];
        mag = (acc < 0) ? -acc : acc;
        if (mag > longint'(DUTY_MAX))
            mag = longint'(DUTY_MAX);
        res.duty_a = back ? '0 : mag[DUTY_W-1:0];
        res.duty_b = back ? mag[DUTY_W-1:0] : '0;
        return res;
    endfunction

    task automatic send_request(input logic back,
                                input logic signed [DATA_W-1:0] target,
                                input logic signed [DATA_W-1:0] measured);
        int gap;
        gap = send_idle_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        backward       <= back;
        target_speed   <= target;
        measured_speed <= measured;
        do
            @(posedge clk);
        while (in_stall);
        expected_duty_q.push_back(advance_drive(back, target, measured));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_duty_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_GAIN_P: kp = value;
            REG_GAIN_I: ki = value;
            REG_GAIN_D: kd = value;
            default: ;
        endcase
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] p,
                             input logic [GAIN_W-1:0] i,
                             input logic [GAIN_W-1:0] d);
        wait_idle();
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, GAIN_W'($urandom));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // With the reset gains every request must leave the drive at zero.
    task automatic test_zero_gains();
        send_request(1'b0, 16'sh7FFF, -16'sh8000);
        send_request(1'b1, -16'sh8000, 16'sh7FFF);
        send_request(1'b0, 16'sh0000, 16'sh0000);
        send_request(1'b1, 16'sd100, 16'sd50);
    endtask

    task automatic test_saturation();
        set_gains(16'h7FFF, 16'h0000, 16'h0000);
        send_request(1'b0, 16'sh7FFF, -16'sh8000);
        send_request(1'b1, 16'sh7FFF, -16'sh8000);
        set_gains(16'h8000, 16'h0000, 16'h0000);
        send_request(1'b0, 16'sh7FFF, -16'sh8000);
        send_request(1'b1, 16'sh0000, 16'sh0000);
        // Unity gain brings the drive from full negative back to zero.
        set_gains(16'h0100, 16'h0000, 16'h0000);
        send_request(1'b0, 16'sd4095, 16'sd0);
        // A tiny gain shows that the shift rounds toward minus infinity.
        set_gains(16'h0001, 16'h0000, 16'h0000);
        send_request(1'b1, -16'sd1, 16'sd0);
        send_request(1'b0, 16'sd1, 16'sd0);
    endtask

    task automatic test_error_history();
        set_gains(16'h0000, 16'h0100, 16'h0100);
        send_request(1'b0, 16'sd10, 16'sd0);
        send_request(1'b0, 16'sd30, 16'sd0);
        send_request(1'b1, 16'sd0, 16'sd5);
        send_request(1'b1, -16'sd20, 16'sd0);
        send_request(1'b0, 16'sd0, 16'sd0);
    endtask

    task automatic test_unused_index();
        set_gains(16'h0040, 16'hFF80, 16'h0020);
        wait_idle();
        write_reg(REG_UNUSED, 16'hFFFF);
        @(negedge clk);
        cfg_write <= 1'b0;
        send_request(1'b0, 16'sd200, 16'sd10);
        send_request(1'b1, -16'sd150, 16'sd40);
        send_request(1'b0, 16'sd77, -16'sd77);
    endtask

    task automatic test_random_traffic(input int total);
        int per_phase;
        per_phase = total / 5;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF);
                2: set_gains(16'h8000, 16'h8000, 16'h8000);
                default: set_gains(pick_gain(), pick_gain(), pick_gain());
            endcase
            send_idle_on = (phase != 0) && (phase != 3);
            recv_idle_on = (phase != 0) && (phase != 4);
            repeat (per_phase)
                send_request(1'($urandom_range(0, 1)), pick_speed(), pick_speed());
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial
    begin
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (recv_idle_on)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        duty_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_duty_q.size() == 0)
                note_failure($sformatf("unexpected result duty_a=%0d duty_b=%0d",
                                       duty_a, duty_b));
            else
            begin
                want = expected_duty_q.pop_front();
                if (duty_a !== want.duty_a || duty_b !== want.duty_b)
                    note_failure($sformatf("duty mismatch: expected a=%0d b=%0d, got a=%0d b=%0d",
                                           want.duty_a, want.duty_b, duty_a, duty_b));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("incremental_pid_motor_drive_core_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_GAIN_P;
        cfg_data       = '0;
        in_valid       = 1'b0;
        backward       = 1'b0;
        target_speed   = '0;
        measured_speed = '0;
        kp             = '0;
        ki             = '0;
        kd             = '0;
        err_last       = '0;
        err_older      = '0;
        drive_acc      = '0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        test_zero_gains();
        test_saturation();
        test_error_history();
        test_unused_index();
        test_random_traffic(850);
        wait_idle();

        if (fail_count == 0)
            $display("incremental_pid_motor_drive_core_tb: PASS");
        else
            $display("incremental_pid_motor_drive_core_tb: FAIL");
        $finish;
    end

endmodule
